// ----- src/searchable_request_fifo_unit_defines.svh -----
// ----------------------------------------------------------------------------
// searchable request fifo assertion macros
// concurrent assertion wrappers clocked on clk_i, disabled while rst_ni is low
// ----------------------------------------------------------------------------
`ifndef SEARCHABLE_REQUEST_FIFO_UNIT_DEFINES_SVH
`define SEARCHABLE_REQUEST_FIFO_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define SRF_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("srf assertion failed");
`define SRF_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("srf implication failed");
`define SRF_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("srf next-cycle check failed");
`else
`define SRF_ASSERT(lbl, prop)
`define SRF_ASSERT_IMP(lbl, ante, cons)
`define SRF_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// ----- src/srf_pkg.sv -----
// ----------------------------------------------------------------------------
// srf_pkg
// shared types, codes and the key canonicalization function
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package srf_pkg;

  localparam int unsigned KEY_BYTES = 29;
  localparam int unsigned CFG_W     = 13;
  localparam int unsigned FIELD_W   = 13;
  localparam logic [CFG_W-1:0] CFG_RESET = 13'd3000;

  typedef struct packed {
    logic [39:0] p3;
    logic [63:0] p2;
    logic [63:0] p1;
    logic [63:0] p0;
  } key_t;

  typedef enum logic [1:0] {
    CMD_ENQ  = 2'd0,
    CMD_DEQ  = 2'd1,
    CMD_PEEK = 2'd2,
    CMD_FIND = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_SCAN,
    S_DONE
  } state_e;

  // clear every byte after the first zero byte
  function automatic key_t canon_key(input key_t k);
    logic [8*KEY_BYTES-1:0] b;
    logic ended;
    b = k;
    ended = 1'b0;
    for (int i = 0; i < KEY_BYTES; i++) begin
      if (ended) begin
        b[8*i +: 8] = 8'h00;
      end else if (b[8*i +: 8] == 8'h00) begin
        ended = 1'b1;
      end
    end
    return key_t'(b);
  endfunction

endpackage

// ----- src/srf_if.sv -----
// ----------------------------------------------------------------------------
// srf request and response channels
// valid/ready channels carrying a command with key and the command result
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface srf_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [63:0] key_part0;
  logic [63:0] key_part1;
  logic [63:0] key_part2;
  logic [39:0] key_part3;

  modport source (
    output valid, command, key_part0, key_part1, key_part2, key_part3,
    input  ready
  );
  modport sink (
    input  valid, command, key_part0, key_part1, key_part2, key_part3,
    output ready
  );
endinterface

interface srf_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic        found;
  logic [12:0] position;
  logic [12:0] fill_count;
  logic [63:0] out_part0;
  logic [63:0] out_part1;
  logic [63:0] out_part2;
  logic [39:0] out_part3;

  modport source (
    output valid, status, found, position, fill_count,
    output out_part0, out_part1, out_part2, out_part3,
    input  ready
  );
  modport sink (
    input  valid, status, found, position, fill_count,
    input  out_part0, out_part1, out_part2, out_part3,
    output ready
  );
endinterface

// ----- src/srf_store.sv -----
// ----------------------------------------------------------------------------
// srf_store
// key storage ram, one write port and one registered read port
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module srf_store #(
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  srf_pkg::key_t            wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output srf_pkg::key_t            rdata_o
);
  import srf_pkg::*;

  key_t mem_q [DEPTH];
  key_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/srf_seq.sv -----
// ----------------------------------------------------------------------------
// srf_seq
// command sequencer with ring pointers, fill count and the shared key compare
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "searchable_request_fifo_unit_defines.svh"

module srf_seq #(
  parameter int unsigned DEPTH = 4096
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [$clog2(DEPTH+1)-1:0] limit_i,
  srf_req_if.sink                    req_i,
  srf_rsp_if.source                  rsp_o,
  output logic                       mem_we_o,
  output logic [$clog2(DEPTH)-1:0]   mem_waddr_o,
  output srf_pkg::key_t              mem_wdata_o,
  output logic                       mem_re_o,
  output logic [$clog2(DEPTH)-1:0]   mem_raddr_o,
  input  srf_pkg::key_t              mem_rdata_i
);
  import srf_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

  state_e            state_q, state_d;
  cmd_e              cmd_q, cmd_d;
  key_t              key_q, key_d, key_in;
  key_t              data_q, data_d;
  status_e           status_q, status_d;
  logic              found_q, found_d;
  logic [CW-1:0]     pos_q, pos_d;
  logic [AW-1:0]     head_q, head_d, tail_q, tail_d, scan_idx_q, scan_idx_d;
  logic [CW-1:0]     count_q, count_d, cmp_n_q, cmp_n_d;
  logic              out_valid_q, out_valid_d;
  logic              load;
  logic              accept;
  logic              match;
  cmd_e              cmd_in;

  status_e           out_status_q;
  logic              out_found_q;
  logic [FIELD_W-1:0] out_pos_q, out_fill_q;
  key_t              out_data_q;

  function automatic logic [AW-1:0] next_idx(input logic [AW-1:0] i);
    return (i == LAST_IDX) ? '0 : i + AW'(1);
  endfunction

  assign req_i.ready = (state_q == S_IDLE);
  assign accept      = req_i.valid && req_i.ready;
  assign cmd_in      = cmd_e'(req_i.command);
  assign key_in      = canon_key(key_t'({req_i.key_part3, req_i.key_part2,
                                         req_i.key_part1, req_i.key_part0}));
  assign match       = (mem_rdata_i == key_q);

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    key_d       = key_q;
    data_d      = data_q;
    status_d    = status_q;
    found_d     = found_q;
    pos_d       = pos_q;
    head_d      = head_q;
    tail_d      = tail_q;
    scan_idx_d  = scan_idx_q;
    count_d     = count_q;
    cmp_n_d     = cmp_n_q;
    out_valid_d = out_valid_q && !rsp_o.ready;
    load        = 1'b0;
    mem_we_o    = 1'b0;
    mem_waddr_o = tail_q;
    mem_wdata_o = key_in;
    mem_re_o    = 1'b0;
    mem_raddr_o = head_q;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_d    = cmd_in;
          key_d    = key_in;
          status_d = ST_OK;
          found_d  = 1'b0;
          pos_d    = '0;
          data_d   = '0;
          case (cmd_in)
            CMD_ENQ: begin
              if (count_q >= limit_i) begin
                status_d = ST_FULL;
              end else begin
                mem_we_o = 1'b1;
                tail_d   = next_idx(tail_q);
                count_d  = count_q + CW'(1);
              end
              state_d = S_DONE;
            end
            CMD_DEQ, CMD_PEEK: begin
              if (count_q == '0) begin
                status_d = ST_EMPTY;
                state_d  = S_DONE;
              end else begin
                mem_re_o = 1'b1;
                state_d  = S_READ;
              end
            end
            CMD_FIND: begin
              if (count_q == '0) begin
                state_d = S_DONE;
              end else begin
                mem_re_o   = 1'b1;
                scan_idx_d = next_idx(head_q);
                cmp_n_d    = '0;
                state_d    = S_SCAN;
              end
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end
      S_READ: begin
        data_d = mem_rdata_i;
        if (cmd_q == CMD_DEQ) begin
          head_d  = next_idx(head_q);
          count_d = count_q - CW'(1);
        end
        state_d = S_DONE;
      end
      S_SCAN: begin
        if (match) begin
          found_d = 1'b1;
          pos_d   = cmp_n_q + CW'(1);
          state_d = S_DONE;
        end else if (cmp_n_q + CW'(1) == count_q) begin
          state_d = S_DONE;
        end else begin
          mem_re_o    = 1'b1;
          mem_raddr_o = scan_idx_q;
          scan_idx_d  = next_idx(scan_idx_q);
          cmp_n_d     = cmp_n_q + CW'(1);
        end
      end
      S_DONE: begin
        if (!out_valid_q || rsp_o.ready) begin
          load        = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    key_q      <= key_d;
    data_q     <= data_d;
    status_q   <= status_d;
    found_q    <= found_d;
    pos_q      <= pos_d;
    scan_idx_q <= scan_idx_d;
    cmp_n_q    <= cmp_n_d;
  end

  // result register, loaded on the way back to idle
  always_ff @(posedge clk_i) begin
    if (load) begin
      out_status_q <= status_q;
      out_found_q  <= found_q;
      out_pos_q    <= FIELD_W'(pos_q);
      out_fill_q   <= FIELD_W'(count_q);
      out_data_q   <= data_q;
    end
  end

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.status     = out_status_q;
  assign rsp_o.found      = out_found_q;
  assign rsp_o.position   = out_pos_q;
  assign rsp_o.fill_count = out_fill_q;
  assign rsp_o.out_part0  = out_data_q.p0;
  assign rsp_o.out_part1  = out_data_q.p1;
  assign rsp_o.out_part2  = out_data_q.p2;
  assign rsp_o.out_part3  = out_data_q.p3;

  `SRF_ASSERT(a_count_bound, count_q <= CW'(DEPTH))
  `SRF_ASSERT_IMP(a_write_below_limit, mem_we_o, count_q < limit_i)
  `SRF_ASSERT_IMP(a_scan_in_fill, state_q == S_SCAN, cmp_n_q < count_q)
  `SRF_ASSERT_NXT(a_done_holds, state_q == S_DONE && out_valid_q && !rsp_o.ready,
                  state_q == S_DONE)

endmodule

// ----- src/searchable_request_fifo_unit.sv -----
// ----------------------------------------------------------------------------
// searchable_request_fifo_unit
// bounded fifo of 29-byte request keys with enqueue, dequeue, peek and find
// enqueue and any command on an empty queue go straight to the result load;
//   dequeue and peek read the head entry first, and find scans from the head
//   until it hits (position is 1-based) or has compared every held entry
// one item at a time: next input transfer in the cycle after the result loads
// find walks the key ram one entry per cycle through its single read port
// reset: queue empty, pointers zero, limit 3000; ram contents are not cleared
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module searchable_request_fifo_unit #(
  parameter int unsigned DEPTH = 4096
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [srf_pkg::CFG_W-1:0]   cfg_wdata_i,
  srf_req_if.sink                     req_i,
  srf_rsp_if.source                   rsp_o
);
  import srf_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned LW = (CW > CFG_W) ? CW : CFG_W;

  logic [CFG_W-1:0] max_q;
  logic [CW-1:0]    limit;
  logic             mem_we, mem_re;
  logic [AW-1:0]    mem_waddr, mem_raddr;
  key_t             mem_wdata, mem_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q <= CFG_RESET;
    end else if (cfg_we_i) begin
      max_q <= cfg_wdata_i;
    end
  end

  // effective limit is the smaller of the register and the ram depth
  assign limit = (LW'(max_q) >= LW'(DEPTH)) ? CW'(DEPTH) : CW'(max_q);

  srf_seq #(
    .DEPTH (DEPTH)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .limit_i     (limit),
    .req_i       (req_i),
    .rsp_o       (rsp_o),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  srf_store #(
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

endmodule

// ----- sim/searchable_request_fifo_checker.sv -----
// ----------------------------------------------------------------------------
// searchable request fifo checker
// watches the request and response channels and the limit register, keeps its
// own queue of held keys to predict each result, and compares every response
// transfer field by field with the oldest prediction
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module searchable_request_fifo_checker #(
  parameter int unsigned DEPTH = 4096
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [srf_pkg::CFG_W-1:0] cfg_wdata_i,
  srf_req_if                        req_i,
  srf_rsp_if                        rsp_i,
  output int unsigned               fail_count_o,
  output int unsigned               pending_o
);

  import srf_pkg::*;

  typedef struct packed {
    status_e     status;
    logic        found;
    logic [12:0] position;
    logic [12:0] fill;
    key_t        data;
  } outcome_t;

  key_t             held_q[$];
  outcome_t         outcome_q[$];
  logic [CFG_W-1:0] limit_q;
  int unsigned      mismatches = 0;

  assign fail_count_o = mismatches;

  // zero every byte that follows the first nul
  function automatic key_t trim_at_nul(key_t raw);
    logic [8*KEY_BYTES-1:0] bytes_v;
    int                     cut;
    bytes_v = raw;
    cut = KEY_BYTES;
    for (int i = KEY_BYTES - 1; i >= 0; i--) begin
      if (bytes_v[8*i +: 8] == 8'h00) cut = i;
    end
    for (int i = 0; i < KEY_BYTES; i++) begin
      if (i > cut) bytes_v[8*i +: 8] = 8'h00;
    end
    return key_t'(bytes_v);
  endfunction

  function automatic outcome_t apply_command(cmd_e cmd, key_t raw);
    outcome_t    o;
    key_t        k;
    int unsigned cap;
    k   = trim_at_nul(raw);
    cap = (limit_q < DEPTH) ? limit_q : DEPTH;
    o   = '0;
    o.status = ST_OK;
    case (cmd)
      CMD_ENQ: begin
        if (held_q.size() >= cap) begin
          o.status = ST_FULL;
        end else begin
          held_q.push_back(k);
        end
      end
      CMD_DEQ, CMD_PEEK: begin
        if (held_q.size() == 0) begin
          o.status = ST_EMPTY;
        end else begin
          o.data = held_q[0];
          if (cmd == CMD_DEQ) void'(held_q.pop_front());
        end
      end
      default: begin
        for (int n = 0; n < held_q.size() && !o.found; n++) begin
          if (held_q[n] == k) begin
            o.found    = 1'b1;
            o.position = 13'(n + 1);
          end
        end
      end
    endcase
    o.fill = 13'(held_q.size());
    return o;
  endfunction

  task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
    $display("%0t ns: mismatch on %s, got %h, expected %h", $time, field, got, want);
    mismatches++;
  endtask

  task automatic check_result(outcome_t want);
    if (rsp_i.status !== want.status)
      report_mismatch("status", 64'(rsp_i.status), 64'(want.status));
    if (rsp_i.found !== want.found)
      report_mismatch("found", 64'(rsp_i.found), 64'(want.found));
    if (rsp_i.position !== want.position)
      report_mismatch("position", 64'(rsp_i.position), 64'(want.position));
    if (rsp_i.fill_count !== want.fill)
      report_mismatch("fill_count", 64'(rsp_i.fill_count), 64'(want.fill));
    if (rsp_i.out_part0 !== want.data.p0)
      report_mismatch("out_part0", rsp_i.out_part0, want.data.p0);
    if (rsp_i.out_part1 !== want.data.p1)
      report_mismatch("out_part1", rsp_i.out_part1, want.data.p1);
    if (rsp_i.out_part2 !== want.data.p2)
      report_mismatch("out_part2", rsp_i.out_part2, want.data.p2);
    if (rsp_i.out_part3 !== want.data.p3)
      report_mismatch("out_part3", 64'(rsp_i.out_part3), 64'(want.data.p3));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q.delete();
      outcome_q.delete();
      limit_q = CFG_RESET;
      pending_o <= 0;
    end else begin
      // response transfer first, a new request may land on the same edge
      if (rsp_i.valid && rsp_i.ready) begin
        if (outcome_q.size() == 0) begin
          report_mismatch("result with nothing pending", 64'(rsp_i.fill_count), 64'd0);
        end else begin
          check_result(outcome_q.pop_front());
        end
      end
      if (cfg_we_i) limit_q = cfg_wdata_i;
      if (req_i.valid && req_i.ready) begin
        outcome_q.push_back(apply_command(cmd_e'(req_i.command),
          {req_i.key_part3, req_i.key_part2, req_i.key_part1, req_i.key_part0}));
      end
      pending_o <= outcome_q.size();
    end
  end

endmodule

// ----- sim/searchable_request_fifo_unit_tb.sv -----
// ----------------------------------------------------------------------------
// searchable request fifo testbench
// drives directed and random enqueue, dequeue, peek and find commands with
// random idling on both channels, walks the fill limit through zero, one,
// small values, full depth and beyond, and reports the verdict from the
// checker's mismatch and pending counts
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module searchable_request_fifo_unit_tb;

  import srf_pkg::*;

  localparam int unsigned FIFO_DEPTH = 4096;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_wdata;
  int unsigned      fail_count;
  int unsigned      pending;
  bit               idle_on;
  key_t             used_keys[$];

  srf_req_if req_ch();
  srf_rsp_if rsp_ch();

  searchable_request_fifo_unit #(
    .DEPTH(FIFO_DEPTH)
  ) u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .req_i      (req_ch),
    .rsp_o      (rsp_ch)
  );

  searchable_request_fifo_checker #(
    .DEPTH(FIFO_DEPTH)
  ) u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .req_i       (req_ch),
    .rsp_i       (rsp_ch),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  initial begin
    #50_000_000;
    $display("FAIL");
    $finish;
  end

  function automatic key_t noise_key();
    logic [255:0] w;
    w = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    return w[8*KEY_BYTES-1:0];
  endfunction

  // len nonzero bytes, a nul, then either zeros or leftover garbage
  function automatic key_t text_key(int len, bit junk);
    logic [8*KEY_BYTES-1:0] b;
    for (int i = 0; i < KEY_BYTES; i++) begin
      if (i < len) begin
        b[8*i +: 8] = 8'($urandom_range(1, 255));
      end else if (i == len || !junk) begin
        b[8*i +: 8] = 8'h00;
      end else begin
        b[8*i +: 8] = 8'($urandom_range(0, 255));
      end
    end
    return key_t'(b);
  endfunction

  function automatic key_t fresh_key();
    case ($urandom_range(0, 3))
      0: return noise_key();
      1: return text_key($urandom_range(0, KEY_BYTES), 1'b0);
      default: return text_key($urandom_range(0, KEY_BYTES), 1'b1);
    endcase
  endfunction

  // same string, new garbage after the nul
  function automatic key_t scramble_tail(key_t k);
    logic [8*KEY_BYTES-1:0] b;
    bit                     ended;
    b = k;
    ended = 1'b0;
    for (int i = 0; i < KEY_BYTES; i++) begin
      if (ended) begin
        b[8*i +: 8] = 8'($urandom_range(0, 255));
      end else if (b[8*i +: 8] == 8'h00) begin
        ended = 1'b1;
      end
    end
    return key_t'(b);
  endfunction

  // returns just after the transfer edge, valid left high unless a gap follows
  task automatic put_item(cmd_e cmd, key_t k);
    req_ch.valid     <= 1'b1;
    req_ch.command   <= cmd;
    req_ch.key_part0 <= k.p0;
    req_ch.key_part1 <= k.p1;
    req_ch.key_part2 <= k.p2;
    req_ch.key_part3 <= k.p3;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    if (cmd == CMD_ENQ) begin
      used_keys.push_back(k);
      if (used_keys.size() > 24) void'(used_keys.pop_front());
    end
    if (idle_on && $urandom_range(0, 3) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    for (int unsigned c = 0; c < 50000 && pending != 0; c++) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_fill_limit(logic [CFG_W-1:0] value);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic random_item();
    int unsigned pick;
    key_t        k;
    pick = $urandom_range(0, 99);
    k = fresh_key();
    if (pick < 35) begin
      put_item(CMD_ENQ, k);
    end else if (pick < 60) begin
      put_item(CMD_DEQ, k);
    end else if (pick < 70) begin
      put_item(CMD_PEEK, k);
    end else begin
      if (used_keys.size() != 0 && $urandom_range(0, 2) != 0) begin
        k = used_keys[$urandom_range(0, used_keys.size() - 1)];
        if ($urandom_range(0, 1) == 1) k = scramble_tail(k);
      end
      put_item(CMD_FIND, k);
    end
  endtask

  // response side stalls in bursts
  initial begin
    rsp_ch.ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (idle_on && $urandom_range(0, 3) == 0) begin
        rsp_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else begin
        rsp_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
    end
  end

  initial begin
    key_t             k;
    key_t             probe;
    logic [CFG_W-1:0] phase_limits[5];

    idle_on          = 1'b1;
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_wdata        = '0;
    req_ch.valid     = 1'b0;
    req_ch.command   = CMD_ENQ;
    req_ch.key_part0 = '0;
    req_ch.key_part1 = '0;
    req_ch.key_part2 = '0;
    req_ch.key_part3 = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty queue
    put_item(CMD_DEQ, noise_key());
    put_item(CMD_PEEK, noise_key());
    put_item(CMD_FIND, '0);
    // key shapes: empty string, no terminator, garbage after nul, longest string
    put_item(CMD_ENQ, '0);
    put_item(CMD_ENQ, '1);
    k = text_key(5, 1'b1);
    put_item(CMD_ENQ, k);
    put_item(CMD_ENQ, text_key(28, 1'b0));
    put_item(CMD_PEEK, '1);
    put_item(CMD_FIND, '1);
    put_item(CMD_FIND, scramble_tail(k));
    probe = noise_key();
    probe.p0[7:0] = 8'h00;
    put_item(CMD_FIND, probe);
    put_item(CMD_FIND, text_key(3, 1'b0));
    put_item(CMD_DEQ, '0);
    // limit of zero, then a limit below the fill
    set_fill_limit('0);
    put_item(CMD_ENQ, k);
    put_item(CMD_FIND, k);
    set_fill_limit(13'd1);
    put_item(CMD_ENQ, k);
    repeat (3) put_item(CMD_DEQ, noise_key());
    put_item(CMD_ENQ, noise_key());
    put_item(CMD_ENQ, noise_key());
    put_item(CMD_DEQ, noise_key());
    put_item(CMD_DEQ, noise_key());

    phase_limits[0] = 13'd4096;
    phase_limits[1] = 13'd2;
    phase_limits[2] = 13'($urandom_range(3, 12));
    phase_limits[3] = 13'd1;
    phase_limits[4] = 13'd6;
    foreach (phase_limits[p]) begin
      set_fill_limit(phase_limits[p]);
      repeat (12) random_item();
    end

    // limit above capacity, deeper search, then drain past empty
    set_fill_limit('1);
    repeat (8) put_item(CMD_ENQ, noise_key());
    put_item(CMD_FIND, used_keys[0]);
    put_item(CMD_FIND, text_key(KEY_BYTES, 1'b0));
    repeat (3) put_item(CMD_DEQ, noise_key());
    repeat (3) put_item(CMD_ENQ, fresh_key());
    put_item(CMD_FIND, used_keys[used_keys.size() - 1]);
    put_item(CMD_PEEK, noise_key());
    repeat (12) put_item(CMD_DEQ, noise_key());

    set_fill_limit(13'd5);
    repeat (8) random_item();
    idle_on = 1'b0;
    repeat (24) random_item();

    wait_drained();
    repeat (8) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+src
src/srf_pkg.sv
src/srf_if.sv
src/srf_store.sv
src/srf_seq.sv
src/searchable_request_fifo_unit.sv
sim/searchable_request_fifo_checker.sv
sim/searchable_request_fifo_unit_tb.sv
